[rtl/erg_pkg.sv]
`default_nettype none
package erg_pkg;

  localparam int unsigned MAX_STEPS = 32;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned DIV_W     = 11;
  localparam int unsigned REM_W     = 7;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;
  localparam logic [1:0] CMD_STATUS  = 2'd3;

  localparam logic [1:0] REG_STEP_COUNT    = 2'd0;
  localparam logic [1:0] REG_FILL_COUNT    = 2'd1;
  localparam logic [1:0] REG_ROTATION      = 2'd2;
  localparam logic [1:0] REG_REPEAT_TARGET = 2'd3;

  localparam logic [5:0] RST_STEP_COUNT    = 6'd16;
  localparam logic [5:0] RST_FILL_COUNT    = 6'd4;
  localparam logic [4:0] RST_ROTATION      = 5'd0;
  localparam logic [7:0] RST_REPEAT_TARGET = 8'd0;

  localparam logic [CNT_W-1:0] ROT_BITS = CNT_W'(POS_W);
  localparam logic [CNT_W-1:0] PAT_BITS = CNT_W'(DIV_W);

  typedef struct packed {
    logic [5:0] step_count;
    logic [5:0] fill_count;
    logic [4:0] rotation;
    logic [7:0] repeat_target;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
    logic [CNT_W-1:0] nbits;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] remainder;
  } rem_rsp_t;

endpackage
`default_nettype wire

[rtl/erg_cfg.sv]
`default_nettype none
module erg_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [erg_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [erg_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [erg_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output erg_pkg::cfg_t                    cfg
);
  import erg_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_STEP_COUNT:    cfg_nxt.step_count    = cfg_pwdata[5:0];
        REG_FILL_COUNT:    cfg_nxt.fill_count    = cfg_pwdata[5:0];
        REG_ROTATION:      cfg_nxt.rotation      = cfg_pwdata[4:0];
        REG_REPEAT_TARGET: cfg_nxt.repeat_target = cfg_pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_STEP_COUNT:    cfg_prdata = DATA_W'(cfg_r.step_count);
      REG_FILL_COUNT:    cfg_prdata = DATA_W'(cfg_r.fill_count);
      REG_ROTATION:      cfg_prdata = DATA_W'(cfg_r.rotation);
      REG_REPEAT_TARGET: cfg_prdata = DATA_W'(cfg_r.repeat_target);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_count    <= RST_STEP_COUNT;
      cfg_r.fill_count    <= RST_FILL_COUNT;
      cfg_r.rotation      <= RST_ROTATION;
      cfg_r.repeat_target <= RST_REPEAT_TARGET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/erg_rem.sv]
`default_nettype none
module erg_rem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  erg_pkg::rem_req_t      req,
  output erg_pkg::rem_rsp_t      rsp
);
  import erg_pkg::*;

  logic [DIV_W-1:0] shift_r, shift_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] divisor_r, divisor_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] trial_red;

  // one dividend bit per cycle, msb first
  assign trial     = {rem_r[REM_W-2:0], shift_r[DIV_W-1]};
  assign trial_red = (trial >= divisor_r) ? trial - divisor_r : trial;

  always_comb begin
    shift_nxt   = shift_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (req.start) begin
      shift_nxt   = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
      cnt_nxt     = req.nbits;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[DIV_W-2:0], 1'b0};
      rem_nxt   = trial_red;
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

[rtl/euclidean_rhythm_sequencer_unit.sv]
`default_nettype none
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_command, in_step_index
// out      output     out_valid/out_stall out_hit, out_position, out_wrapped, out_repeat_end
// cfg      input      apb write/read      step_count, fill_count, rotation, repeat_target
//
// one transaction at a time; when the pattern bit must be worked out, the shared bit-serial
// remainder unit runs twice (5 bits of rotation, then 11 bits of pattern); it is skipped
// when the position lies beyond the cycle or there are no fills
// rst_n is synchronous, active low; clears position, cycle count, registers and control
// a waiting result sits in the output register; a stalled output holds the next result back
module euclidean_rhythm_sequencer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_command,
  input  wire logic [4:0]                  in_step_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic      [4:0]                  out_position,
  output logic                             out_wrapped,
  output logic                             out_repeat_end,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [erg_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [erg_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [erg_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import erg_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RSTART = 7'b0000010,
    ST_RWAIT  = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_MSTART = 7'b0010000,
    ST_MWAIT  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  cfg_t      cfg;
  rem_req_t  req;
  rem_rsp_t  rsp;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] step_pos_r, step_pos_nxt;
  logic [7:0]       cycle_cnt_r, cycle_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [POS_W-1:0] q_r, q_nxt;
  logic [POS_W-1:0] u_r, u_nxt;
  logic [DIV_W-1:0] n_r, n_nxt;
  logic             hit_r, hit_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             wrap_r, wrap_nxt;
  logic             rend_r, rend_nxt;

  logic             out_hit_r, out_hit_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_wrap_r, out_wrap_nxt;
  logic             out_rend_r, out_rend_nxt;

  logic [STEP_W-1:0] s_eff;
  logic [STEP_W-1:0] f_eff;
  logic              accept;
  logic [POS_W-1:0]  q_in;
  logic [STEP_W:0]   u_sum;
  logic [STEP_W:0]   u_red;
  logic [11:0]       prod;
  logic [7:0]        cc_inc;
  logic              out_free;

  erg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  erg_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    if (cfg.step_count == '0) begin
      s_eff = STEP_W'(1);
    end else if (cfg.step_count > STEP_W'(MAX_STEPS)) begin
      s_eff = STEP_W'(MAX_STEPS);
    end else begin
      s_eff = cfg.step_count;
    end
    f_eff = (cfg.fill_count > s_eff) ? s_eff : cfg.fill_count;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;

  // unrotated index: (q + s - r) mod s
  assign u_sum = (STEP_W+1)'(q_r) + (STEP_W+1)'(s_eff) - rsp.remainder;
  assign u_red = (u_sum >= (STEP_W+1)'(s_eff)) ? u_sum - (STEP_W+1)'(s_eff) : u_sum;
  // hit when (f*(2u+1) - 1) mod 2s < 2f
  assign prod   = 12'(f_eff) * 12'({u_r, 1'b1}) - 12'd1;
  assign cc_inc = (cfg.repeat_target != '0) ? cycle_cnt_r + 8'd1 : cycle_cnt_r;

  always_comb begin
    case (in_command)
      CMD_RESTART: q_in = '0;
      CMD_PEEK:    q_in = in_step_index;
      default:     q_in = step_pos_r;
    endcase
  end

  always_comb begin
    req.start    = 1'b0;
    req.dividend = {cfg.rotation, (DIV_W-POS_W)'(0)};
    req.divisor  = REM_W'(s_eff);
    req.nbits    = ROT_BITS;
    case (state_r)
      ST_RSTART: req.start = 1'b1;
      ST_MSTART: begin
        req.start    = 1'b1;
        req.dividend = n_r;
        req.divisor  = {s_eff, 1'b0};
        req.nbits    = PAT_BITS;
      end
      default: req.start = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_pos_nxt  = step_pos_r;
    cycle_cnt_nxt = cycle_cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    q_nxt         = q_r;
    u_nxt         = u_r;
    n_nxt         = n_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    wrap_nxt      = wrap_r;
    rend_nxt      = rend_r;
    out_hit_nxt   = out_hit_r;
    out_pos_nxt   = out_pos_r;
    out_wrap_nxt  = out_wrap_r;
    out_rend_nxt  = out_rend_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          q_nxt    = q_in;
          pos_nxt  = (in_command == CMD_RESTART) ? '0 : step_pos_r;
          wrap_nxt = 1'b0;
          rend_nxt = 1'b0;
          hit_nxt  = 1'b0;
          if (in_command == CMD_TICK) begin
            if ((STEP_W'(step_pos_r) + STEP_W'(1)) < s_eff) begin
              step_pos_nxt = step_pos_r + POS_W'(1);
            end else begin
              step_pos_nxt  = '0;
              wrap_nxt      = 1'b1;
              cycle_cnt_nxt = cc_inc;
              if (cc_inc >= cfg.repeat_target) begin
                cycle_cnt_nxt = '0;
                rend_nxt      = 1'b1;
              end
            end
          end else if (in_command == CMD_RESTART) begin
            step_pos_nxt = '0;
          end
          if ((STEP_W'(q_in) >= s_eff) || (f_eff == '0)) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_RSTART;
          end
        end
      end
      ST_RSTART: state_nxt = ST_RWAIT;
      ST_RWAIT: begin
        if (rsp.done) begin
          u_nxt     = u_red[POS_W-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        n_nxt     = prod[DIV_W-1:0];
        state_nxt = ST_MSTART;
      end
      ST_MSTART: state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (rsp.done) begin
          hit_nxt   = (rsp.remainder < {f_eff, 1'b0});
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_pos_nxt   = pos_r;
          out_wrap_nxt  = wrap_r;
          out_rend_nxt  = rend_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_pos_r  <= '0;
      cycle_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_pos_r  <= step_pos_nxt;
      cycle_cnt_r <= cycle_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    u_r        <= u_nxt;
    n_r        <= n_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    wrap_r     <= wrap_nxt;
    rend_r     <= rend_nxt;
    out_hit_r  <= out_hit_nxt;
    out_pos_r  <= out_pos_nxt;
    out_wrap_r <= out_wrap_nxt;
    out_rend_r <= out_rend_nxt;
  end

  assign out_hit        = out_hit_r;
  assign out_position   = out_pos_r;
  assign out_wrapped    = out_wrap_r;
  assign out_repeat_end = out_rend_r;

endmodule
`default_nettype wire

[verif/euclidean_rhythm_sequencer_unit_test.sv]
`timescale 1ns / 100ps
module euclidean_rhythm_sequencer_unit_test;
  import erg_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [4:0] position;
    logic       wrapped;
    logic       repeat_end;
  } seq_result_t;

  typedef struct packed {
    logic        is_write;
    logic [1:0]  reg_sel;
    logic [7:0]  value;
    logic [1:0]  cmd;
    logic [4:0]  idx;
    logic        typed;
    seq_result_t want;
  } stim_row_t;

  localparam int PLAN_LEN = 35;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_command = CMD_TICK;
  logic [4:0]        in_step_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic [4:0]        out_position;
  logic              out_wrapped;
  logic              out_repeat_end;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  euclidean_rhythm_sequencer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_step_index  (in_step_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_position   (out_position),
    .out_wrapped    (out_wrapped),
    .out_repeat_end (out_repeat_end),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // shadow registers and sequencer state
  logic [5:0] cfg_steps;
  logic [5:0] cfg_fills;
  logic [4:0] cfg_rot;
  logic [7:0] cfg_target;
  logic [4:0] seq_pos;
  logic [7:0] wrap_count;

  seq_result_t step_results_due [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  int          hold_left = 0;
  stim_row_t   plan [PLAN_LEN];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned steps_in_cycle();
    int unsigned s;
    s = cfg_steps;
    if (s == 0) s = 1;
    if (s > MAX_STEPS) s = MAX_STEPS;
    return s;
  endfunction

  function automatic logic rhythm_hit(input logic [4:0] at);
    int unsigned s, f, u, k;
    s = steps_in_cycle();
    f = cfg_fills;
    if (f > s) f = s;
    if (at >= s || f == 0) return 1'b0;
    u = (at + s - (cfg_rot % s)) % s;
    for (k = 0; k < f; k++) begin
      if ((2 * k * s + f) / (2 * f) == u) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic seq_result_t advance_sequencer(input logic [1:0] cmd,
                                                    input logic [4:0] idx);
    seq_result_t r;
    int unsigned s;
    r = '0;
    r.position = seq_pos;
    s = steps_in_cycle();
    case (cmd)
      CMD_TICK: begin
        r.hit = rhythm_hit(seq_pos);
        if (seq_pos + 1 < s) begin
          seq_pos = seq_pos + 5'd1;
        end else begin
          seq_pos = '0;
          r.wrapped = 1'b1;
          if (cfg_target != 8'd0) wrap_count = wrap_count + 8'd1;
          if (wrap_count >= cfg_target) begin
            wrap_count = '0;
            r.repeat_end = 1'b1;
          end
        end
      end
      CMD_RESTART: begin
        seq_pos = '0;
        r.position = '0;
        r.hit = rhythm_hit(5'd0);
      end
      CMD_PEEK: begin
        r.hit = rhythm_hit(idx);
      end
      default: begin
        r.hit = rhythm_hit(seq_pos);
      end
    endcase
    return r;
  endfunction

  task automatic reg_write(input logic [1:0] r, input logic [7:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({r, 2'b00});
    cfg_pwdata <= DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (r)
      REG_STEP_COUNT: cfg_steps = v[5:0];
      REG_FILL_COUNT: cfg_fills = v[5:0];
      REG_ROTATION:   cfg_rot = v[4:0];
      default:        cfg_target = v;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (step_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic offer_step(input logic [1:0] cmd, input logic [4:0] idx,
                            input logic typed, input seq_result_t want);
    seq_result_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_step_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_sequencer(cmd, idx);
    step_results_due.push_back(typed ? want : predicted);
  endtask

  // result side: stall pattern, long hold-off and checking
  always @(posedge clk) begin
    seq_result_t got, due;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_hit, out_position, out_wrapped, out_repeat_end};
      if (step_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: hit=%0d pos=%0d wrap=%0d rend=%0d",
                   got.hit, got.position, got.wrapped, got.repeat_end);
      end else begin
        due = step_results_due.pop_front();
        if (got != due) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch hit/pos/wrap/rend: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     due.hit, due.position, due.wrapped, due.repeat_end,
                     got.hit, got.position, got.wrapped, got.repeat_end);
        end
      end
    end
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int          seg, n, pick;
    logic [1:0]  cmd;
    logic [7:0]  steps_v, fills_v, target_v;

    plan = '{
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b1, '{1'b1, 5'd0, 1'b0, 1'b0}},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_STATUS,  5'd31, 1'b1, '{1'b0, 5'd1, 1'b0, 1'b0}},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_PEEK,    5'd4,  1'b1, '{1'b1, 5'd1, 1'b0, 1'b0}},
      // peek out of range
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_PEEK,    5'd31, 1'b1, '{1'b0, 5'd1, 1'b0, 1'b0}},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_RESTART, 5'd17, 1'b1, '{1'b1, 5'd0, 1'b0, 1'b0}},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd21, 1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd10, 1'b0, '0},
      // shrink the cycle below the current position
      '{1'b1, REG_STEP_COUNT,    8'd2,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_STATUS,  5'd0,  1'b1, '{1'b0, 5'd3, 1'b0, 1'b0}},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b1, '{1'b0, 5'd3, 1'b1, 1'b1}},
      // zero steps, zero fills, target zero
      '{1'b1, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b1, REG_FILL_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd31, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b1}},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_PEEK,    5'd0,  1'b1, '{1'b0, 5'd0, 1'b0, 1'b0}},
      '{1'b1, REG_FILL_COUNT,    8'd63, CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b1, REG_REPEAT_TARGET, 8'd255, CMD_TICK,   5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b1, '{1'b1, 5'd0, 1'b1, 1'b0}},
      // saturating step count, largest rotation
      '{1'b1, REG_STEP_COUNT,    8'd63, CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b1, REG_ROTATION,      8'd31, CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b1, REG_REPEAT_TARGET, 8'd1,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_PEEK,    5'd31, 1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_PEEK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_STATUS,  5'd0,  1'b0, '0},
      '{1'b1, REG_STEP_COUNT,    8'd7,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b1, REG_FILL_COUNT,    8'd3,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b1, REG_ROTATION,      8'd5,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_RESTART, 5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd31, 1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd31, 1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd31, 1'b0, '0},
      '{1'b0, REG_STEP_COUNT,    8'd0,  CMD_TICK,    5'd0,  1'b0, '0}
    };

    cfg_steps = RST_STEP_COUNT;
    cfg_fills = RST_FILL_COUNT;
    cfg_rot = RST_ROTATION;
    cfg_target = RST_REPEAT_TARGET;
    seq_pos = '0;
    wrap_count = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < PLAN_LEN; n++) begin
      if (plan[n].is_write) begin
        drain_results();
        reg_write(plan[n].reg_sel, plan[n].value);
      end else begin
        offer_step(plan[n].cmd, plan[n].idx, plan[n].typed, plan[n].want);
      end
    end

    for (seg = 0; seg < 8; seg++) begin
      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      pick = $urandom_range(9);
      case (pick)
        0:       steps_v = 8'd0;
        1:       steps_v = 8'd63;
        2:       steps_v = 8'd32;
        3:       steps_v = 8'($urandom_range(63));
        default: steps_v = 8'($urandom_range(8, 1));
      endcase
      pick = $urandom_range(9);
      case (pick)
        0:       fills_v = 8'd0;
        1:       fills_v = 8'd63;
        2:       fills_v = steps_v;
        3:       fills_v = 8'($urandom_range(63));
        default: fills_v = 8'($urandom_range(8));
      endcase
      pick = $urandom_range(9);
      case (pick)
        0:       target_v = 8'd0;
        1:       target_v = 8'd255;
        default: target_v = 8'($urandom_range(4, 1));
      endcase
      reg_write(REG_STEP_COUNT, steps_v);
      reg_write(REG_FILL_COUNT, fills_v);
      reg_write(REG_ROTATION, 8'($urandom_range(31)));
      reg_write(REG_REPEAT_TARGET, target_v);

      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // long hold-off on the result side while transactions keep coming
      if (seg == 4) hold_go = 1'b1;

      for (n = 0; n < 50; n++) begin
        pick = $urandom_range(99);
        if (pick < 60) cmd = CMD_TICK;
        else if (pick < 70) cmd = CMD_RESTART;
        else if (pick < 85) cmd = CMD_PEEK;
        else cmd = CMD_STATUS;
        offer_step(cmd, 5'($urandom_range(31)), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (step_results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && step_results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
